// ===== design/bpq_pkg.sv =====
// Package for the bounded priority queue: widths, codes and the entry type.
// No dependencies; every other file of the block imports it.
package bpq_pkg;

   // Default built capacity
   localparam int BPQ_DEPTH = 16;

   // Field widths
   localparam int TAG_W      = 16;
   localparam int PRIO_W     = 8;
   localparam int COUNT_W    = 5;
   localparam int LIMIT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Request operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORDERED_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT  = 1'b1;

   // One stored entry
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
   } entry_type;

endpackage

// ===== design/bpq_req_if.sv =====
// Request channel of the bounded priority queue: push or pop one entry.
// Depends on bpq_pkg.
interface bpq_req_if import bpq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [TAG_W-1:0]  item_tag;
   logic [PRIO_W-1:0] item_priority;

   modport source (output valid, mode, item_tag, item_priority, input ready);
   modport sink   (input valid, mode, item_tag, item_priority, output ready);
endinterface

// ===== design/bpq_rsp_if.sv =====
// Result channel of the bounded priority queue: outcome and occupancy.
// Depends on bpq_pkg.
interface bpq_rsp_if import bpq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [TAG_W-1:0]   out_tag;
   logic [PRIO_W-1:0]  out_priority;
   logic               is_empty;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, ok, out_tag, out_priority, is_empty, entry_count,
                   input ready);
   modport sink   (input valid, ok, out_tag, out_priority, is_empty, entry_count,
                   output ready);
endinterface

// ===== design/bpq_csr_if.sv =====
// Configuration write channel of the bounded priority queue.
// Depends on bpq_pkg.
interface bpq_csr_if import bpq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bounded_priority_queue_top.sv =====
// Bounded priority queue: circular entry memory with a read-modify-write sequencer.
// Depends on bpq_pkg, bpq_req_if, bpq_rsp_if and bpq_csr_if.
//
// Usage:
//   req_chan carries one request: push (tag, priority) or pop the head entry.
//   rsp_chan returns exactly one result per request: ok, the popped entry
//   (zero on push or failed pop), the empty flag and the entry count.
//   csr_chan writes ordered_mode (index 0) and queue_limit (index 1); it is
//   always ready, and the user must write it only while no request is in
//   flight; the block itself does not enforce this.
// Sequencing:
//   A push in FIFO mode, a push into an empty queue, a refused push and a pop
//   of an empty queue finish in the accept cycle. A pop holds the registered
//   read of the head entry in ST_POP until the result register frees. An
//   ordered push walks the memory from head to tail one entry a cycle, reading
//   one slot while writing the previous one, and rippling later entries one slot back.
// Reset clears the state, count, head pointer, result valid flag and configuration;
// the entry memory is not cleared, since only slots holding entries are ever read.
// A stalled receiver holds the result register; the next request is taken
// only once that register is free or being emptied in the same cycle.
module bounded_priority_queue_top import bpq_pkg::*; #(
   parameter int DEPTH = BPQ_DEPTH
) (
   input logic        clock,
   input logic        reset,
   bpq_req_if.sink    req_chan,
   bpq_rsp_if.source  rsp_chan,
   bpq_csr_if.sink    csr_chan
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_POP  = 2'd1;
   localparam logic [1:0] ST_INS  = 2'd2;

   // Entry memory
   entry_type entry_mem [DEPTH];
   entry_type rd_data_ff;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   entry_type       wr_data;

   // Control state
   logic [1:0]      state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [CW-1:0]   step_ff, step_in;
   logic            found_ff, found_in;
   entry_type       carry_ff, carry_in;
   logic            ordered_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic          rsp_free;
   logic          req_fire;
   logic          can_push;
   logic [AW:0]   tail_sum;
   logic [AW-1:0] tail_addr;
   logic [AW-1:0] addr_next;
   logic [AW-1:0] head_next;
   entry_type     req_entry;

   // Address arithmetic
   always_comb begin
      tail_sum  = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
      tail_addr = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
      addr_next = (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);
      head_next = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);
   end

   // Handshake and admission
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign can_push  = (count_ff < DEPTH_C)
                   && ((limit_ff == '0) || (CMPW'(count_ff) < CMPW'(limit_ff)));
   assign req_entry = '{tag: req_chan.item_tag, prio: req_chan.item_priority};

   // Sequencer: decode, pop read, ordered insert walk
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      addr_in      = addr_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      carry_in     = carry_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_addr;
      wr_data      = req_entry;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.mode == OP_POP) begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b0;
                     rsp_entry_in = '0;
                     rsp_empty_in = 1'b1;
                     rsp_count_in = '0;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = ST_POP;
                  end
               end else if (!can_push) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_entry_in = '0;
                  rsp_empty_in = (count_ff == '0);
                  rsp_count_in = COUNT_W'(count_ff);
               end else if (!ordered_ff || count_ff == '0) begin
                  // append at the tail
                  wr_en        = 1'b1;
                  wr_addr      = tail_addr;
                  wr_data      = req_entry;
                  count_in     = count_ff + CW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_entry_in = '0;
                  rsp_empty_in = 1'b0;
                  rsp_count_in = COUNT_W'(count_in);
               end else begin
                  // start the insert walk at the head
                  carry_in = req_entry;
                  found_in = 1'b0;
                  step_in  = '0;
                  addr_in  = head_ff;
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  state_in = ST_INS;
               end
            end
         end

         ST_POP: begin
            // hold the read data until the result register frees
            if (rsp_free) begin
               count_in     = count_ff - CW'(1);
               head_in      = head_next;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rsp_entry_in = rd_data_ff;
               rsp_empty_in = (count_in == '0);
               rsp_count_in = COUNT_W'(count_in);
               state_in     = ST_IDLE;
            end
         end

         ST_INS: begin
            if (step_ff == count_ff) begin
               // drop the carried entry into the tail slot
               if (rsp_free) begin
                  wr_en        = 1'b1;
                  wr_addr      = addr_ff;
                  wr_data      = carry_ff;
                  count_in     = count_ff + CW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_entry_in = '0;
                  rsp_empty_in = 1'b0;
                  rsp_count_in = COUNT_W'(count_in);
                  state_in     = ST_IDLE;
               end
            end else begin
               // once the insert point is passed, ripple entries one slot back
               if (found_ff || (rd_data_ff.prio > carry_ff.prio)) begin
                  wr_en    = 1'b1;
                  wr_addr  = addr_ff;
                  wr_data  = carry_ff;
                  carry_in = rd_data_ff;
                  found_in = 1'b1;
               end
               addr_in = addr_next;
               step_in = step_ff + CW'(1);
               rd_en   = 1'b1;
               rd_addr = addr_next;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory port: one registered read, one write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      carry_ff     <= carry_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ordered_ff <= 1'b0;
         limit_ff   <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_ORDERED_MODE: ordered_ff <= csr_chan.data[0];
            CSR_QUEUE_LIMIT:  limit_ff   <= LIMIT_W'(csr_chan.data);
            default: begin
            end
         endcase
      end
   end

   // Result channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_ok_ff;
   assign rsp_chan.out_tag      = rsp_entry_ff.tag;
   assign rsp_chan.out_priority = rsp_entry_ff.prio;
   assign rsp_chan.is_empty     = rsp_empty_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above capacity");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_chan.ready)
      else $error("request taken while the sequencer is busy");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |-> (step_ff <= count_ff))
      else $error("insert walk ran past the tail");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write to the same slot in one cycle");
`endif

endmodule
